/* design/spmq_pkg.sv */
package spmq_pkg;

   localparam int LEVELS_DEF = 5;
   localparam int DEPTH_DEF  = 16;

   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 3;
   localparam int FUNC_W   = 1;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 3;
   localparam int TOTAL_W  = 7;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } spmq_func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PUSHED   = 3'd0,
      ST_BAD_PRIO = 3'd1,
      ST_FULL     = 3'd2,
      ST_POPPED   = 3'd3,
      ST_EMPTY    = 3'd4
   } spmq_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } spmq_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic finish_pop;
   } spmq_cmd_type;

   typedef struct packed {
      logic pop_hit;
   } spmq_sts_type;

endpackage

/* design/strict_priority_multi_fifo_unit.sv */
// Channel   Direction  Fields
// req_      in         tuser: func; tdata: value, priority_req
// rsp_      out        tuser: status; tdata: popped_level, popped_value, total_count,
//                      queue_empty
//
// One word is in flight at a time. A push, or a pop that finds every level empty, goes
// IDLE, EXEC, RESP; a pop that finds an entry adds a READ state after EXEC, for the
// registered read of the entry memory. Synchronous reset clears the pointers and counts
// at once; the entry memory is not cleared and needs no clearing pass. While a result
// waits on rsp_tready, req_tready stays low.
module strict_priority_multi_fifo_unit #(
   parameter int LEVELS = spmq_pkg::LEVELS_DEF,
   parameter int DEPTH  = spmq_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value, [34:32] priority_req, [39:35] zero
   input  logic [spmq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] func
   input  logic [spmq_pkg::FUNC_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] popped_level, [34:3] popped_value, [41:35] total_count, [42] queue_empty,
   // [47:43] zero
   output logic [spmq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [2:0] status
   output logic [spmq_pkg::STATUS_W-1:0]       rsp_tuser
);

   spmq_pkg::spmq_cmd_type cmd;
   spmq_pkg::spmq_sts_type sts;

   logic [spmq_pkg::LEVEL_W-1:0] popped_level;
   logic [spmq_pkg::VALUE_W-1:0] popped_value;
   logic [spmq_pkg::TOTAL_W-1:0] total_count;
   logic                         queue_empty;

   spmq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   spmq_dp #(
      .LEVELS (LEVELS),
      .DEPTH  (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_func     (req_tuser),
      .req_value    (req_tdata[31:0]),
      .req_prio     (req_tdata[34:32]),
      .status       (rsp_tuser),
      .popped_level (popped_level),
      .popped_value (popped_value),
      .total_count  (total_count),
      .queue_empty  (queue_empty)
   );

   assign rsp_tdata = {5'd0, queue_empty, total_count, popped_value, popped_level};

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result presented in the cycle after acceptance");

   a_zero_when_not_popped: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != spmq_pkg::ST_POPPED) |-> (rsp_tdata[34:0] == '0))
      else $error("popped fields nonzero on a result that popped nothing");

endmodule

/* design/spmq_ctrl.sv */
module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output spmq_pkg::spmq_cmd_type cmd,
   input  spmq_pkg::spmq_sts_type sts
);

   spmq_pkg::spmq_state_type state_ff;
   spmq_pkg::spmq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spmq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spmq_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = spmq_pkg::S_EXEC;
            end
         end
         spmq_pkg::S_EXEC: begin
            state_in = sts.pop_hit ? spmq_pkg::S_READ : spmq_pkg::S_RESP;
         end
         spmq_pkg::S_READ: begin
            state_in = spmq_pkg::S_RESP;
         end
         spmq_pkg::S_RESP: begin
            if (rsp_tready) begin
               state_in = spmq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spmq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == spmq_pkg::S_IDLE);
      rsp_tvalid     = (state_ff == spmq_pkg::S_RESP);
      cmd.load       = (state_ff == spmq_pkg::S_IDLE) && req_tvalid;
      cmd.exec       = (state_ff == spmq_pkg::S_EXEC);
      cmd.finish_pop = (state_ff == spmq_pkg::S_READ);
   end

endmodule

/* design/spmq_dp.sv */
module spmq_dp #(
   parameter int LEVELS = spmq_pkg::LEVELS_DEF,
   parameter int DEPTH  = spmq_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spmq_pkg::spmq_cmd_type            cmd,
   output spmq_pkg::spmq_sts_type            sts,
   input  logic [spmq_pkg::FUNC_W-1:0]       req_func,
   input  logic [spmq_pkg::VALUE_W-1:0]      req_value,
   input  logic [spmq_pkg::PRIO_W-1:0]       req_prio,
   output logic [spmq_pkg::STATUS_W-1:0]     status,
   output logic [spmq_pkg::LEVEL_W-1:0]      popped_level,
   output logic [spmq_pkg::VALUE_W-1:0]      popped_value,
   output logic [spmq_pkg::TOTAL_W-1:0]      total_count,
   output logic                              queue_empty
);

   localparam int LW      = $clog2(LEVELS);
   localparam int PW      = $clog2(DEPTH);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int ENTRIES = LEVELS * DEPTH;
   localparam int AW      = $clog2(ENTRIES);
   localparam int TW      = $clog2(ENTRIES + 1);

   logic [spmq_pkg::FUNC_W-1:0]  func_ff;
   logic [spmq_pkg::VALUE_W-1:0] value_ff;
   logic [spmq_pkg::PRIO_W-1:0]  prio_ff;

   logic [PW-1:0] head_ff  [LEVELS];
   logic [PW-1:0] tail_ff  [LEVELS];
   logic [CW-1:0] count_ff [LEVELS];
   logic [TW-1:0] total_ff;

   spmq_pkg::spmq_status_type    status_ff;
   spmq_pkg::spmq_status_type    status_in;
   logic [LW-1:0]                level_ff;
   logic [spmq_pkg::VALUE_W-1:0] pvalue_ff;
   logic [spmq_pkg::VALUE_W-1:0] rd_data_ff;
   logic [spmq_pkg::VALUE_W-1:0] mem [ENTRIES];

   logic          is_pop;
   logic          prio_ok;
   logic          lvl_full;
   logic          any_ne;
   logic [LW-1:0] push_lvl;
   logic [LW-1:0] pop_lvl;
   logic [LW-1:0] act_lvl;
   logic [PW-1:0] slot;
   logic [AW-1:0] addr;
   logic          do_push;
   logic          do_pop;

   function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      is_pop   = (func_ff == spmq_pkg::FUNC_POP);
      prio_ok  = ({29'd0, prio_ff} < 32'(LEVELS));
      push_lvl = LW'(prio_ff);
      lvl_full = (count_ff[push_lvl] == CW'(DEPTH));
      any_ne   = 1'b0;
      pop_lvl  = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            any_ne  = 1'b1;
            pop_lvl = LW'(i);
         end
      end
      act_lvl = is_pop ? pop_lvl : push_lvl;
      slot    = is_pop ? head_ff[act_lvl] : tail_ff[act_lvl];
      addr    = AW'(act_lvl) * AW'(DEPTH) + AW'(slot);
      do_push = cmd.exec && !is_pop && prio_ok && !lvl_full;
      do_pop  = cmd.exec && is_pop && any_ne;
   end

   always_comb begin
      priority if (is_pop) begin
         status_in = any_ne ? spmq_pkg::ST_POPPED : spmq_pkg::ST_EMPTY;
      end else if (!prio_ok) begin
         status_in = spmq_pkg::ST_BAD_PRIO;
      end else if (lvl_full) begin
         status_in = spmq_pkg::ST_FULL;
      end else begin
         status_in = spmq_pkg::ST_PUSHED;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_value;
         prio_ff  <= req_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         total_ff <= '0;
      end else begin
         if (do_push) begin
            tail_ff[act_lvl]  <= wrap_next(tail_ff[act_lvl]);
            count_ff[act_lvl] <= count_ff[act_lvl] + CW'(1);
            total_ff          <= total_ff + TW'(1);
         end
         if (do_pop) begin
            head_ff[act_lvl]  <= wrap_next(head_ff[act_lvl]);
            count_ff[act_lvl] <= count_ff[act_lvl] - CW'(1);
            total_ff          <= total_ff - TW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[addr] <= value_ff;
      end
      if (do_pop) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         level_ff  <= do_pop ? pop_lvl : '0;
         pvalue_ff <= '0;
      end
      if (cmd.finish_pop) begin
         pvalue_ff <= rd_data_ff;
      end
   end

   assign sts.pop_hit   = is_pop && any_ne;
   assign status        = status_ff;
   assign popped_level  = spmq_pkg::LEVEL_W'(level_ff);
   assign popped_value  = pvalue_ff;
   assign total_count   = spmq_pkg::TOTAL_W'(total_ff);
   assign queue_empty   = (total_ff == '0);

endmodule

/* tb/tb_strict_priority_multi_fifo_unit.sv */
module tb_strict_priority_multi_fifo_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LEVELS  = spmq_pkg::LEVELS_DEF;
   localparam int LEVEL_DEPTH = spmq_pkg::DEPTH_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 250;

   typedef struct packed {
      spmq_pkg::spmq_status_type          status;
      logic [spmq_pkg::LEVEL_W-1:0]       level;
      logic [spmq_pkg::VALUE_W-1:0]       value;
      logic [spmq_pkg::TOTAL_W-1:0]       total;
      logic                               empty;
   } queue_outcome_type;

   class level_queue_scoreboard;
      logic [spmq_pkg::VALUE_W-1:0] slots [NUM_LEVELS][LEVEL_DEPTH];
      int unsigned        head_slot [NUM_LEVELS];
      int unsigned        tail_slot [NUM_LEVELS];
      int unsigned        fill [NUM_LEVELS];
      int unsigned        stored;
      queue_outcome_type  pending_results [$];
      int                 errors;

      function new();
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_slot[l] = 0;
            tail_slot[l] = 0;
            fill[l] = 0;
         end
         stored = 0;
         errors = 0;
      endfunction

      function void note_request(spmq_pkg::spmq_func_type f,
                                 logic [spmq_pkg::VALUE_W-1:0] v,
                                 logic [spmq_pkg::PRIO_W-1:0] p);
         queue_outcome_type o;
         o = '0;
         if (f == spmq_pkg::FUNC_PUSH) begin
            if (p >= NUM_LEVELS) begin
               o.status = spmq_pkg::ST_BAD_PRIO;
            end else if (fill[p] >= LEVEL_DEPTH) begin
               o.status = spmq_pkg::ST_FULL;
            end else begin
               slots[p][tail_slot[p]] = v;
               tail_slot[p] = (tail_slot[p] + 1) % LEVEL_DEPTH;
               fill[p]++;
               stored++;
               o.status = spmq_pkg::ST_PUSHED;
            end
         end else begin
            o.status = spmq_pkg::ST_EMPTY;
            for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
               if (fill[l] != 0 && o.status == spmq_pkg::ST_EMPTY) begin
                  o.value = slots[l][head_slot[l]];
                  head_slot[l] = (head_slot[l] + 1) % LEVEL_DEPTH;
                  fill[l]--;
                  stored--;
                  o.level = l[spmq_pkg::LEVEL_W-1:0];
                  o.status = spmq_pkg::ST_POPPED;
               end
            end
         end
         o.total = stored[spmq_pkg::TOTAL_W-1:0];
         o.empty = (stored == 0);
         pending_results.insert(pending_results.size(), o);
      endfunction

      function void check_response(logic [spmq_pkg::STATUS_W-1:0] st,
                                   logic [spmq_pkg::LEVEL_W-1:0] lvl,
                                   logic [spmq_pkg::VALUE_W-1:0] val,
                                   logic [spmq_pkg::TOTAL_W-1:0] total,
                                   logic empty);
         queue_outcome_type o;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word status %0d level %0d value %h total %0d empty %0d",
                     $time, st, lvl, val, total, empty);
            errors++;
         end else begin
            o = pending_results.pop_front();
            if (st !== o.status) begin
               $display("%0t: status expected %0d got %0d", $time, o.status, st);
               errors++;
            end
            if (lvl !== o.level) begin
               $display("%0t: popped_level expected %0d got %0d", $time, o.level, lvl);
               errors++;
            end
            if (val !== o.value) begin
               $display("%0t: popped_value expected %h got %h", $time, o.value, val);
               errors++;
            end
            if (total !== o.total) begin
               $display("%0t: total_count expected %0d got %0d", $time, o.total, total);
               errors++;
            end
            if (empty !== o.empty) begin
               $display("%0t: queue_empty expected %0d got %0d", $time, o.empty, empty);
               errors++;
            end
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [spmq_pkg::REQ_TDATA_W-1:0]    req_tdata;
   logic [spmq_pkg::FUNC_W-1:0]         req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [spmq_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic [spmq_pkg::STATUS_W-1:0]       rsp_tuser;

   level_queue_scoreboard   sb;
   logic                    no_idle;
   int                      results_seen;
   int                      quiet_cycles;

   strict_priority_multi_fifo_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   task automatic send_word(input spmq_pkg::spmq_func_type f,
                            input logic [spmq_pkg::VALUE_W-1:0] v,
                            input logic [spmq_pkg::PRIO_W-1:0] p);
      if (!no_idle) begin
         while ($urandom_range(99) < 26) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {5'b0, p, v};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_request(f, v, p);
      @(negedge clock);
   endtask

   function automatic logic [spmq_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tuser, rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[41:35],
                           rsp_tdata[42]);
         results_seen <= results_seen + 1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && results_seen >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
         @(negedge clock);
      end
   end

   initial begin
      int push_pct;
      int favored;
      logic [spmq_pkg::PRIO_W-1:0] p;
      spmq_pkg::spmq_func_type f;
      sb = new();
      no_idle = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(spmq_pkg::FUNC_POP, 32'h1234_5678, 3'd0);
      send_word(spmq_pkg::FUNC_PUSH, 32'hDEAD_BEEF, 3'd5);
      send_word(spmq_pkg::FUNC_PUSH, 32'h0000_0001, 3'd7);
      send_word(spmq_pkg::FUNC_PUSH, 32'h8000_0000, 3'd0);
      send_word(spmq_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 3'd1);
      send_word(spmq_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 3'd3);
      send_word(spmq_pkg::FUNC_PUSH, 32'h0000_0000, 3'd4);
      for (int i = 0; i < LEVEL_DEPTH; i++) begin
         send_word(spmq_pkg::FUNC_PUSH, (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555, 3'd2);
      end
      send_word(spmq_pkg::FUNC_PUSH, 32'h0BAD_F00D, 3'd2);

      for (int chunk = 0; chunk < 16; chunk++) begin
         push_pct = $urandom_range(15, 85);
         favored = ($urandom_range(1) == 1) ? int'($urandom_range(NUM_LEVELS - 1)) : -1;
         no_idle = (chunk == 6 || chunk == 7);
         for (int i = 0; i < 100; i++) begin
            f = ($urandom_range(99) < push_pct) ? spmq_pkg::FUNC_PUSH : spmq_pkg::FUNC_POP;
            if ($urandom_range(99) < 8) begin
               p = spmq_pkg::PRIO_W'($urandom_range(7, NUM_LEVELS));
            end else if (favored >= 0 && $urandom_range(99) < 70) begin
               p = favored[spmq_pkg::PRIO_W-1:0];
            end else begin
               p = spmq_pkg::PRIO_W'($urandom_range(NUM_LEVELS - 1));
            end
            send_word(f, pick_value(), p);
         end
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
